/* src/slxfp_pkg.sv */
// ----------------------------------------------------------------------------
// slxfp_pkg
// Types and constants shared by the sync/length/XOR frame parser.
// ----------------------------------------------------------------------------
`default_nettype none

package slxfp_pkg;

   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 8;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_SYNC_BYTE       = 3'd0,
      CSR_CHECKSUM_MASK   = 3'd1,
      CSR_NAME_COMMAND    = 3'd2,
      CSR_VERSION_COMMAND = 3'd3,
      CSR_RESET_COMMAND   = 3'd4,
      CSR_BOOT_COMMAND    = 3'd5
   } csr_index_type;

   localparam logic [7:0] SYNC_BYTE_RESET       = 8'hFE;
   localparam logic [7:0] CHECKSUM_MASK_RESET   = 8'h80;
   localparam logic [7:0] NAME_COMMAND_RESET    = 8'h01;
   localparam logic [7:0] VERSION_COMMAND_RESET = 8'h02;
   localparam logic [7:0] RESET_COMMAND_RESET   = 8'h03;
   localparam logic [7:0] BOOT_COMMAND_RESET    = 8'h04;

   localparam logic [3:0] ERROR_NIBBLE = 4'hE;

   localparam logic [7:0] VERSION_SIZE_PACKED = 8'd2;
   localparam logic [7:0] VERSION_SIZE_SHORT  = 8'd3;
   localparam logic [7:0] VERSION_SIZE_FULL   = 8'd4;

   typedef enum logic [2:0] {
      KIND_BAD_SUM     = 3'd0,
      KIND_ERROR       = 3'd1,
      KIND_NAME        = 3'd2,
      KIND_VERSION     = 3'd3,
      KIND_BAD_VERSION = 3'd4,
      KIND_RESET       = 3'd5,
      KIND_BOOT        = 3'd6,
      KIND_NORMAL      = 3'd7
   } kind_type;

   typedef enum logic [3:0] {
      ST_HUNT,
      ST_SIZE,
      ST_CMD,
      ST_DATA,
      ST_DISPATCH,
      ST_VFETCH,
      ST_VCAP,
      ST_PFETCH,
      ST_PSEND,
      ST_SEND_ONE
   } state_type;

   typedef struct packed {
      logic take_sync;
      logic take_size;
      logic take_cmd;
      logic take_data;
      logic idx_clear;
      logic idx_step;
      logic rd_en;
      logic ver_cap;
      logic load_one;
      logic load_byte;
   } ctrl_cmd_type;

   typedef struct packed {
      logic     sync_match;
      logic     data_full;
      logic     data_done;
      kind_type kind;
      logic     pay_empty;
      logic     idx_last;
      logic     ver_done;
      logic     out_free;
   } dp_status_type;

   typedef struct packed {
      kind_type   frame_kind;
      logic [7:0] command_code;
      logic [5:0] payload_length;
      logic [5:0] byte_index;
      logic [7:0] payload_byte;
      logic       byte_valid;
      logic [7:0] version_major;
      logic [7:0] version_minor;
      logic [7:0] version_patch;
      logic       last;
   } rsp_data_type;

endpackage

`default_nettype wire

/* src/slxfp_req_if.sv */
// ----------------------------------------------------------------------------
// slxfp_req_if
// Request channel: one received serial byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface slxfp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

/* src/slxfp_rsp_if.sv */
// ----------------------------------------------------------------------------
// slxfp_rsp_if
// Result channel: one parsed frame result or payload byte per request.
// ----------------------------------------------------------------------------
`default_nettype none

interface slxfp_rsp_if;
   logic       valid;
   logic       ready;
   logic [2:0] frame_kind;
   logic [7:0] command_code;
   logic [5:0] payload_length;
   logic [5:0] byte_index;
   logic [7:0] payload_byte;
   logic       byte_valid;
   logic [7:0] version_major;
   logic [7:0] version_minor;
   logic [7:0] version_patch;
   logic       last;

   modport source (
      output valid, output frame_kind, output command_code, output payload_length,
      output byte_index, output payload_byte, output byte_valid,
      output version_major, output version_minor, output version_patch,
      output last, input ready
   );
   modport sink (
      input valid, input frame_kind, input command_code, input payload_length,
      input byte_index, input payload_byte, input byte_valid,
      input version_major, input version_minor, input version_patch,
      input last, output ready
   );
endinterface

`default_nettype wire

/* src/slxfp_ram.sv */
// ----------------------------------------------------------------------------
// slxfp_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

/* src/slxfp_ctrl.sv */
// ----------------------------------------------------------------------------
// slxfp_ctrl
// Frame parser controller: header/data phases and end-of-frame readout.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire slxfp_pkg::dp_status_type status,
   output slxfp_pkg::ctrl_cmd_type       cmd
);
   import slxfp_pkg::*;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_HUNT;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         ST_HUNT: begin
            req_ready = 1'b1;
            if (req_valid && status.sync_match) begin
               cmd.take_sync = 1'b1;
               state_in      = ST_SIZE;
            end
         end
         ST_SIZE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_size = 1'b1;
               state_in      = ST_CMD;
            end
         end
         ST_CMD: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.take_cmd = 1'b1;
               state_in     = ST_DATA;
            end
         end
         ST_DATA: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (status.data_full) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.take_data = 1'b1;
                  if (status.data_done) begin
                     state_in = ST_DISPATCH;
                  end
               end
            end
         end
         ST_DISPATCH: begin
            cmd.idx_clear = 1'b1;
            if (status.kind inside {KIND_NAME, KIND_NORMAL}) begin
               state_in = status.pay_empty ? ST_SEND_ONE : ST_PFETCH;
            end else if (status.kind == KIND_VERSION) begin
               state_in = ST_VFETCH;
            end else begin
               state_in = ST_SEND_ONE;
            end
         end
         ST_VFETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_VCAP;
         end
         ST_VCAP: begin
            cmd.ver_cap = 1'b1;
            if (status.ver_done) begin
               state_in = ST_SEND_ONE;
            end else begin
               cmd.idx_step = 1'b1;
               state_in     = ST_VFETCH;
            end
         end
         ST_PFETCH: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_PSEND;
         end
         ST_PSEND: begin
            if (status.out_free) begin
               cmd.load_byte = 1'b1;
               if (status.idx_last) begin
                  state_in = ST_HUNT;
               end else begin
                  cmd.idx_step = 1'b1;
                  state_in     = ST_PFETCH;
               end
            end
         end
         ST_SEND_ONE: begin
            if (status.out_free) begin
               cmd.load_one = 1'b1;
               state_in     = ST_HUNT;
            end
         end
         default: begin
            state_in = ST_HUNT;
         end
      endcase
   end

endmodule

`default_nettype wire

/* src/slxfp_datapath.sv */
// ----------------------------------------------------------------------------
// slxfp_datapath
// Frame parser datapath: config registers, header capture, checksum,
// payload store, version capture and the result register.
// ----------------------------------------------------------------------------
`default_nettype none

module slxfp_datapath #(
   parameter int MAX_DATA = 64
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                csr_we,
   input  wire logic [slxfp_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [slxfp_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  wire logic [7:0]                          rx_byte,
   input  wire slxfp_pkg::ctrl_cmd_type             cmd,
   output slxfp_pkg::dp_status_type                 status,
   input  wire logic                                rsp_ready,
   output logic                                     rsp_valid,
   output slxfp_pkg::rsp_data_type                  rsp_data
);
   import slxfp_pkg::*;

   localparam int CW = $clog2(MAX_DATA);

   logic [7:0] sync_byte_ff, checksum_mask_ff, name_command_ff;
   logic [7:0] version_command_ff, reset_command_ff, boot_command_ff;

   logic [7:0]    size_ff, size_in;
   logic [7:0]    command_ff, command_in;
   logic [7:0]    xor_ff, xor_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] idx_ff, idx_in;
   kind_type      kind_ff, kind_in;
   logic [7:0]    ver_ff [3];

   logic         out_valid_ff, out_valid_in;
   rsp_data_type out_ff, out_in;

   logic [7:0] rd_data;
   logic       sum_ok;
   kind_type   kind_eval;
   logic [7:0] ver_major, ver_minor, ver_patch;
   logic       out_free;

   always_ff @(posedge clock) begin
      if (reset) begin
         sync_byte_ff       <= SYNC_BYTE_RESET;
         checksum_mask_ff   <= CHECKSUM_MASK_RESET;
         name_command_ff    <= NAME_COMMAND_RESET;
         version_command_ff <= VERSION_COMMAND_RESET;
         reset_command_ff   <= RESET_COMMAND_RESET;
         boot_command_ff    <= BOOT_COMMAND_RESET;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SYNC_BYTE:       sync_byte_ff       <= csr_wdata;
            CSR_CHECKSUM_MASK:   checksum_mask_ff   <= csr_wdata;
            CSR_NAME_COMMAND:    name_command_ff    <= csr_wdata;
            CSR_VERSION_COMMAND: version_command_ff <= csr_wdata;
            CSR_RESET_COMMAND:   reset_command_ff   <= csr_wdata;
            CSR_BOOT_COMMAND:    boot_command_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   slxfp_ram #(
      .WIDTH (8),
      .DEPTH (MAX_DATA)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.take_data),
      .wr_addr (count_ff),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign sum_ok = ((xor_ff | checksum_mask_ff) == rx_byte);

   always_comb begin
      if (!sum_ok) begin
         kind_eval = KIND_BAD_SUM;
      end else if (command_ff[7:4] == ERROR_NIBBLE) begin
         kind_eval = KIND_ERROR;
      end else if (command_ff == name_command_ff) begin
         kind_eval = KIND_NAME;
      end else if (command_ff == version_command_ff) begin
         if (size_ff == VERSION_SIZE_PACKED || size_ff == VERSION_SIZE_SHORT ||
             size_ff == VERSION_SIZE_FULL) begin
            kind_eval = KIND_VERSION;
         end else begin
            kind_eval = KIND_BAD_VERSION;
         end
      end else if (command_ff == reset_command_ff) begin
         kind_eval = KIND_RESET;
      end else if (command_ff == boot_command_ff) begin
         kind_eval = KIND_BOOT;
      end else begin
         kind_eval = KIND_NORMAL;
      end
   end

   always_comb begin
      ver_major = 8'd0;
      ver_minor = 8'd0;
      ver_patch = 8'd0;
      if (kind_ff == KIND_VERSION) begin
         if (size_ff == VERSION_SIZE_FULL) begin
            ver_major = ver_ff[0];
            ver_minor = ver_ff[1];
            ver_patch = ver_ff[2];
         end else if (size_ff == VERSION_SIZE_SHORT) begin
            ver_major = ver_ff[0];
            ver_minor = ver_ff[1];
         end else begin
            // packed form: mmm nnn pp
            ver_major = {5'd0, ver_ff[0][7:5]};
            ver_minor = {5'd0, ver_ff[0][4:2]};
            ver_patch = {6'd0, ver_ff[0][1:0]};
         end
      end
   end

   assign out_free = !out_valid_ff || rsp_ready;

   always_comb begin
      size_in    = size_ff;
      command_in = command_ff;
      xor_in     = xor_ff;
      count_in   = count_ff;
      idx_in     = idx_ff;
      kind_in    = kind_ff;
      if (cmd.take_sync) begin
         xor_in   = rx_byte;
         count_in = '0;
      end
      if (cmd.take_size) begin
         size_in = rx_byte;
         xor_in  = xor_ff ^ rx_byte;
      end
      if (cmd.take_cmd) begin
         command_in = rx_byte;
         xor_in     = xor_ff ^ rx_byte;
      end
      if (cmd.take_data) begin
         count_in = count_ff + 1'b1;
         xor_in   = xor_ff ^ rx_byte;
         kind_in  = kind_eval;
      end
      if (cmd.idx_clear) begin
         idx_in = '0;
      end else if (cmd.idx_step) begin
         idx_in = idx_ff + 1'b1;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff && !rsp_ready;
      out_in       = out_ff;
      if (cmd.load_one || cmd.load_byte) begin
         out_valid_in          = 1'b1;
         out_in.frame_kind     = kind_ff;
         out_in.command_code   = command_ff;
         out_in.payload_length = 6'(size_ff - 8'd1);
         out_in.byte_index     = cmd.load_byte ? 6'(idx_ff) : 6'd0;
         out_in.payload_byte   = cmd.load_byte ? rd_data : 8'd0;
         out_in.byte_valid     = cmd.load_byte;
         out_in.version_major  = cmd.load_byte ? 8'd0 : ver_major;
         out_in.version_minor  = cmd.load_byte ? 8'd0 : ver_minor;
         out_in.version_patch  = cmd.load_byte ? 8'd0 : ver_patch;
         out_in.last           = cmd.load_byte ? status.idx_last : 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      size_ff    <= size_in;
      command_ff <= command_in;
      xor_ff     <= xor_in;
      count_ff   <= count_in;
      idx_ff     <= idx_in;
      kind_ff    <= kind_in;
      out_ff     <= out_in;
      if (cmd.ver_cap) begin
         ver_ff[idx_ff[1:0]] <= rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else begin
         out_valid_ff <= out_valid_in;
      end
   end

   assign status.sync_match = (rx_byte == sync_byte_ff);
   assign status.data_full  = (9'(count_ff) >= 9'(MAX_DATA - 1));
   assign status.data_done  = ((9'(count_ff) + 9'd1) == {1'b0, size_ff});
   assign status.kind       = kind_ff;
   assign status.pay_empty  = (size_ff == 8'd1);
   assign status.idx_last   = ((9'(idx_ff) + 9'd2) == {1'b0, size_ff});
   assign status.ver_done   = (idx_ff == CW'(2));
   assign status.out_free   = out_free;

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

endmodule

`default_nettype wire

/* src/sync_length_xor_frame_parser.sv */
// ----------------------------------------------------------------------------
// sync_length_xor_frame_parser
// Serial frame parser: sync, size, command, data and XOR checksum; frames
// are classified and name/normal payloads are read out byte by byte.
// ----------------------------------------------------------------------------
// Header and data bytes are taken one per clock. When the checksum byte
// completes a frame, intake stops for the readout: a dispatch state, then
// a payload memory read and a result load per payload byte for name and
// normal frames, a read and a capture for each of three version bytes and
// then a result load for version frames, and one result load for other
// kinds or an empty payload, each load waiting for a free result register.
// Intake resumes as the last result loads; an untaken result does not stop it.
`default_nettype none

module sync_length_xor_frame_parser #(
   parameter int MAX_DATA = 64
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              csr_we,
   input  wire logic [slxfp_pkg::CSR_INDEX_W-1:0] csr_index,
   input  wire logic [slxfp_pkg::CSR_DATA_W-1:0]  csr_wdata,
   slxfp_req_if.sink                              req_ch,
   slxfp_rsp_if.source                            rsp_ch
);
   import slxfp_pkg::*;

   ctrl_cmd_type  cmd;
   dp_status_type status;
   rsp_data_type  rsp_data;

   slxfp_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   slxfp_datapath #(
      .MAX_DATA (MAX_DATA)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rx_byte   (req_ch.rx_byte),
      .cmd       (cmd),
      .status    (status),
      .rsp_ready (rsp_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_data  (rsp_data)
   );

   assign rsp_ch.frame_kind     = rsp_data.frame_kind;
   assign rsp_ch.command_code   = rsp_data.command_code;
   assign rsp_ch.payload_length = rsp_data.payload_length;
   assign rsp_ch.byte_index     = rsp_data.byte_index;
   assign rsp_ch.payload_byte   = rsp_data.payload_byte;
   assign rsp_ch.byte_valid     = rsp_data.byte_valid;
   assign rsp_ch.version_major  = rsp_data.version_major;
   assign rsp_ch.version_minor  = rsp_data.version_minor;
   assign rsp_ch.version_patch  = rsp_data.version_patch;
   assign rsp_ch.last           = rsp_data.last;

endmodule

`default_nettype wire

/* tb/sv/frame_check_pkg.sv */
// ----------------------------------------------------------------------------
// frame_check_pkg
// Scoreboard for the sync/length/XOR frame parser. It tracks the parse state
// from every accepted request byte, queues the results a finished frame
// should give, and checks each result taken from the block field by field.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package frame_check_pkg;
   import slxfp_pkg::*;

   localparam int FRAME_DATA_LIMIT = 64;

   typedef enum logic [1:0] {
      SEEK_SYNC,
      TAKE_SIZE,
      TAKE_CMD,
      TAKE_DATA
   } parse_phase_type;

   class frame_scoreboard;
      logic [7:0]      sync_val;
      logic [7:0]      mask_val;
      logic [7:0]      name_cmd;
      logic [7:0]      version_cmd;
      logic [7:0]      reset_cmd;
      logic [7:0]      boot_cmd;

      parse_phase_type phase;
      logic [7:0]      size_q;
      logic [7:0]      cmd_q;
      logic [7:0]      xor_q;
      int unsigned     stored;
      logic [7:0]      store [FRAME_DATA_LIMIT];

      rsp_data_type    expected_results [$];
      int              failures;
      int              checked;
      int              kind_count [8];

      function new();
         sync_val    = SYNC_BYTE_RESET;
         mask_val    = CHECKSUM_MASK_RESET;
         name_cmd    = NAME_COMMAND_RESET;
         version_cmd = VERSION_COMMAND_RESET;
         reset_cmd   = RESET_COMMAND_RESET;
         boot_cmd    = BOOT_COMMAND_RESET;
         failures    = 0;
         checked     = 0;
         foreach (kind_count[k]) kind_count[k] = 0;
         restart();
      endfunction

      function void restart();
         phase  = SEEK_SYNC;
         size_q = 8'd0;
         cmd_q  = 8'd0;
         xor_q  = 8'd0;
         stored = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [7:0] value);
         case (idx)
            CSR_SYNC_BYTE:       sync_val    = value;
            CSR_CHECKSUM_MASK:   mask_val    = value;
            CSR_NAME_COMMAND:    name_cmd    = value;
            CSR_VERSION_COMMAND: version_cmd = value;
            CSR_RESET_COMMAND:   reset_cmd   = value;
            CSR_BOOT_COMMAND:    boot_cmd    = value;
            default: ;
         endcase
      endfunction

      function int unsigned waiting();
         return expected_results.size();
      endfunction

      function void add_result(kind_type kind, logic [5:0] idx, logic [7:0] data,
                               logic valid, logic [7:0] major, logic [7:0] minor,
                               logic [7:0] patch, logic final_one);
         rsp_data_type r;
         logic [7:0]   len;
         len              = size_q - 8'd1;
         r.frame_kind     = kind;
         r.command_code   = cmd_q;
         r.payload_length = len[5:0];
         r.byte_index     = idx;
         r.payload_byte   = data;
         r.byte_valid     = valid;
         r.version_major  = major;
         r.version_minor  = minor;
         r.version_patch  = patch;
         r.last           = final_one;
         expected_results.push_back(r);
      endfunction

      function void close_frame(logic [7:0] chk);
         logic [7:0] n;
         kind_type   kind;
         n = size_q - 8'd1;
         if ((xor_q | mask_val) != chk) begin
            add_result(KIND_BAD_SUM, 0, 0, 0, 0, 0, 0, 1);
         end else if (cmd_q[7:4] == ERROR_NIBBLE) begin
            add_result(KIND_ERROR, 0, 0, 0, 0, 0, 0, 1);
         end else if (cmd_q == name_cmd || (cmd_q != version_cmd &&
                      cmd_q != reset_cmd && cmd_q != boot_cmd)) begin
            kind = (cmd_q == name_cmd) ? KIND_NAME : KIND_NORMAL;
            if (n == 8'd0) begin
               add_result(kind, 0, 0, 0, 0, 0, 0, 1);
            end else begin
               for (int i = 0; i < n; i++)
                  add_result(kind, 6'(i), store[i], 1, 0, 0, 0, i == n - 1);
            end
         end else if (cmd_q == version_cmd) begin
            case (size_q)
               VERSION_SIZE_FULL:
                  add_result(KIND_VERSION, 0, 0, 0, store[0], store[1], store[2], 1);
               VERSION_SIZE_SHORT:
                  add_result(KIND_VERSION, 0, 0, 0, store[0], store[1], 8'd0, 1);
               VERSION_SIZE_PACKED:
                  add_result(KIND_VERSION, 0, 0, 0, {5'd0, store[0][7:5]},
                             {5'd0, store[0][4:2]}, {6'd0, store[0][1:0]}, 1);
               default:
                  add_result(KIND_BAD_VERSION, 0, 0, 0, 0, 0, 0, 1);
            endcase
         end else if (cmd_q == reset_cmd) begin
            add_result(KIND_RESET, 0, 0, 0, 0, 0, 0, 1);
         end else begin
            add_result(KIND_BOOT, 0, 0, 0, 0, 0, 0, 1);
         end
      endfunction

      function void note_request(logic [7:0] b);
         case (phase)
            SEEK_SYNC: begin
               if (b == sync_val) begin
                  phase = TAKE_SIZE;
                  xor_q = b;
               end
            end
            TAKE_SIZE: begin
               size_q = b;
               xor_q ^= b;
               phase  = TAKE_CMD;
            end
            TAKE_CMD: begin
               cmd_q = b;
               xor_q ^= b;
               phase = TAKE_DATA;
            end
            default: begin
               // overlong frame: dropped silently, byte discarded
               if (stored >= FRAME_DATA_LIMIT - 1) begin
                  restart();
               end else begin
                  store[stored] = b;
                  stored++;
                  if (stored == size_q) begin
                     close_frame(b);
                     restart();
                  end else begin
                     xor_q ^= b;
                  end
               end
            end
         endcase
      endfunction

      function void compare_field(string field, logic [7:0] want, logic [7:0] got);
         if (want !== got) begin
            $error("%s mismatch: expected 0x%0h, actual 0x%0h", field, want, got);
            failures++;
         end
      endfunction

      function void check_result(rsp_data_type got);
         rsp_data_type want;
         checked++;
         kind_count[got.frame_kind]++;
         if (expected_results.size() == 0) begin
            $error("result with nothing expected: kind %0d command 0x%0h",
                   got.frame_kind, got.command_code);
            failures++;
            return;
         end
         want = expected_results.pop_front();
         compare_field("frame_kind", want.frame_kind, got.frame_kind);
         compare_field("command_code", want.command_code, got.command_code);
         compare_field("payload_length", want.payload_length, got.payload_length);
         compare_field("byte_index", want.byte_index, got.byte_index);
         compare_field("payload_byte", want.payload_byte, got.payload_byte);
         compare_field("byte_valid", want.byte_valid, got.byte_valid);
         compare_field("version_major", want.version_major, got.version_major);
         compare_field("version_minor", want.version_minor, got.version_minor);
         compare_field("version_patch", want.version_patch, got.version_patch);
         compare_field("last", want.last, got.last);
      endfunction
   endclass

endpackage

/* tb/sv/testbench.sv */
// ----------------------------------------------------------------------------
// testbench
// Drives serial bytes into the frame parser with random gaps and random
// result back-pressure. Directed frames cover every frame kind but bad version
// first, then random frames mixed with noise, corrupted checksums and overlong
// frames run under several register settings, extremes and code collisions among them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
   import slxfp_pkg::*;
   import frame_check_pkg::*;

   localparam int RESET_CYCLES    = 12;
   localparam int MAX_GAP         = 12;
   localparam int ITEMS_PER_PHASE = 52;
   localparam int SETTLE_CYCLES   = 24;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int SIDE_REQ        = 0;
   localparam int SIDE_RSP        = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_LO = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE_HI = 3'd7;

   logic                   clock;
   logic                   reset;
   logic                   csr_we;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_wdata;

   slxfp_req_if req_ch ();
   slxfp_rsp_if rsp_ch ();

   sync_length_xor_frame_parser #(.MAX_DATA(FRAME_DATA_LIMIT)) dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch)
   );

   frame_scoreboard sb;
   int sent     = 0;
   int settings = 1;
   int calm_left [2];
   bit calm_on [2];

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // runs of zero-gap items and runs of randomly gapped ones, picked at random
   function automatic int draw_gap(input int side);
      if (calm_left[side] == 0) begin
         calm_on[side]   = ($urandom_range(0, 2) == 0);
         calm_left[side] = $urandom_range(10, 50);
      end
      calm_left[side]--;
      return calm_on[side] ? 0 : $urandom_range(0, MAX_GAP);
   endfunction

   task automatic send_byte(input logic [7:0] b);
      int gap;
      gap = draw_gap(SIDE_REQ);
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.rx_byte <= b;
      do @(posedge clock); while (!(req_ch.valid === 1'b1 && req_ch.ready === 1'b1));
      sb.note_request(b);
      sent++;
   endtask

   task automatic send_frame(input logic [7:0] size, input logic [7:0] cmd,
                             input bit corrupt);
      logic [7:0] sum;
      logic [7:0] b;
      sum = sb.sync_val ^ size ^ cmd;
      send_byte(sb.sync_val);
      send_byte(size);
      send_byte(cmd);
      if (size == 8'd0 || size >= FRAME_DATA_LIMIT) begin
         // never completes: the byte after the last storable one drops it
         repeat (FRAME_DATA_LIMIT) send_byte(8'($urandom));
      end else begin
         repeat (size - 1) begin
            b = 8'($urandom);
            sum ^= b;
            send_byte(b);
         end
         sum |= sb.mask_val;
         if (corrupt) sum ^= 8'($urandom_range(1, 255));
         send_byte(sum);
      end
   endtask

   task automatic send_noise();
      logic [7:0] b;
      bit         loose;
      loose = ($urandom_range(0, 7) == 0);
      repeat ($urandom_range(1, 3)) begin
         b = 8'($urandom);
         if (!loose && b == sb.sync_val) b = ~b;
         send_byte(b);
      end
   endtask

   task automatic random_frame();
      logic [7:0] size;
      logic [7:0] cmd;
      int         pick;
      pick = $urandom_range(0, 9);
      case (pick)
         0, 1:    cmd = sb.name_cmd;
         2, 3:    cmd = sb.version_cmd;
         4:       cmd = sb.reset_cmd;
         5:       cmd = sb.boot_cmd;
         6:       cmd = {ERROR_NIBBLE, 4'($urandom)};
         default: cmd = 8'($urandom);
      endcase
      if (cmd == sb.version_cmd && $urandom_range(0, 3) != 0) begin
         size = 8'($urandom_range(1, 5));
      end else begin
         pick = $urandom_range(0, 99);
         if (pick < 70)      size = 8'($urandom_range(1, 8));
         else if (pick < 92) size = 8'($urandom_range(9, 62));
         else if (pick < 97) size = 8'(FRAME_DATA_LIMIT - 1);
         else if (pick < 98) size = 8'd0;
         else                size = 8'($urandom_range(FRAME_DATA_LIMIT, 255));
      end
      send_frame(size, cmd, $urandom_range(0, 7) == 0);
   endtask

   task automatic run_random(input int budget);
      int framed;
      int mark;
      framed = 0;
      while (framed < budget) begin
         if ($urandom_range(0, 3) == 0) send_noise();
         mark = sent;
         random_frame();
         framed += sent - mark;
      end
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (sb.waiting() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx, input logic [7:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      sb.write_reg(idx, value);
   endtask

   task automatic apply_setting(input logic [7:0] sync_v, input logic [7:0] mask_v,
                                input logic [7:0] name_v, input logic [7:0] version_v,
                                input logic [7:0] reset_v, input logic [7:0] boot_v);
      drain();
      csr_write(CSR_SYNC_BYTE, sync_v);
      csr_write(CSR_CHECKSUM_MASK, mask_v);
      csr_write(CSR_NAME_COMMAND, name_v);
      csr_write(CSR_VERSION_COMMAND, version_v);
      csr_write(CSR_RESET_COMMAND, reset_v);
      csr_write(CSR_BOOT_COMMAND, boot_v);
      // spare indexes must not disturb anything
      csr_write(CSR_SPARE_LO, 8'($urandom));
      csr_write(CSR_SPARE_HI, 8'($urandom));
      csr_we <= 1'b0;
      settings++;
   endtask

   // result side: random stalls, every accepted result checked
   initial begin
      int           gap;
      rsp_data_type got;
      rsp_ch.ready = 1'b0;
      wait (reset === 1'b0);
      @(posedge clock);
      forever begin
         gap = draw_gap(SIDE_RSP);
         if (gap > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1));
         got.frame_kind     = kind_type'(rsp_ch.frame_kind);
         got.command_code   = rsp_ch.command_code;
         got.payload_length = rsp_ch.payload_length;
         got.byte_index     = rsp_ch.byte_index;
         got.payload_byte   = rsp_ch.payload_byte;
         got.byte_valid     = rsp_ch.byte_valid;
         got.version_major  = rsp_ch.version_major;
         got.version_minor  = rsp_ch.version_minor;
         got.version_patch  = rsp_ch.version_patch;
         got.last           = rsp_ch.last;
         sb.check_result(got);
      end
   end

   initial begin
      repeat (CYCLE_LIMIT) @(posedge clock);
      $display("timeout after %0d cycles, %0d results still expected",
               CYCLE_LIMIT, sb.waiting());
      $display("Verification failed");
      $finish;
   end

   initial begin
      sb             = new();
      reset          = 1'b1;
      csr_we         = 1'b0;
      csr_index      = CSR_SYNC_BYTE;
      csr_wdata      = 8'd0;
      req_ch.valid   = 1'b0;
      req_ch.rx_byte = 8'd0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // directed: ignored bytes, then one frame of each kind but bad version
      send_byte(8'h00);
      send_byte(8'hFF);
      send_frame(8'd1, sb.reset_cmd, 1'b0);
      send_frame(8'd1, sb.boot_cmd, 1'b0);
      send_frame(8'd1, {ERROR_NIBBLE, 4'h7}, 1'b0);
      send_frame(VERSION_SIZE_PACKED, sb.version_cmd, 1'b0);
      send_frame(8'd1, sb.name_cmd, 1'b0);
      send_frame(8'd2, 8'h5A, 1'b0);
      send_frame(8'd1, 8'h5A, 1'b1);

      run_random(ITEMS_PER_PHASE);
      apply_setting(8'h00, 8'h00, 8'hFF, 8'h00, 8'h7F, 8'h80);
      run_random(ITEMS_PER_PHASE);
      apply_setting(8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h80, 8'h7F);
      run_random(ITEMS_PER_PHASE);
      // name shadows version, reset shadows boot
      apply_setting(8'hAA, 8'h81, 8'h22, 8'h22, 8'h33, 8'h33);
      run_random(ITEMS_PER_PHASE);
      // error nibble takes precedence over a matching name code
      apply_setting(8'h55, 8'h0F, 8'hE1, 8'h10, 8'h20, 8'h30);
      run_random(ITEMS_PER_PHASE);
      apply_setting(8'($urandom), 8'($urandom), 8'($urandom), 8'($urandom),
                    8'($urandom), 8'($urandom));
      run_random(ITEMS_PER_PHASE);

      drain();
      $display("%0d request bytes, %0d results checked, %0d register settings",
               sent, sb.checked, settings);
      $display("by kind: bad sum %0d, error %0d, name %0d, version %0d, bad version %0d, %s",
               sb.kind_count[KIND_BAD_SUM], sb.kind_count[KIND_ERROR],
               sb.kind_count[KIND_NAME], sb.kind_count[KIND_VERSION],
               sb.kind_count[KIND_BAD_VERSION],
               $sformatf("reset %0d, boot %0d, normal %0d", sb.kind_count[KIND_RESET],
                         sb.kind_count[KIND_BOOT], sb.kind_count[KIND_NORMAL]));
      if (sb.failures == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule
